>>> rtl/core/brslr_pkg.sv
// Shared types and constants for the banded row score / log ratio block.
// Holds field widths, register and status codes, the sequencer state type
// and the divider command/response structs. No dependencies.
package brslr_pkg;

   localparam int unsigned MaxBeadsDefault = 4096;

   localparam int unsigned BeadRegW = 13;
   localparam int unsigned BandW    = 12;
   localparam int unsigned ValueW   = 32;
   localparam int unsigned RowW     = 12;
   localparam int unsigned MeanW    = 32;
   localparam int unsigned IdxW     = 23;
   localparam int unsigned StatusW  = 2;
   localparam int unsigned SumW     = 44;
   localparam int unsigned CsrIdxW  = 2;
   localparam int unsigned CsrDataW = 13;

   // shared restoring divider
   localparam int unsigned DivW     = 64;
   localparam int unsigned DivisorW = 32;
   localparam int unsigned StepW    = 7;

   // log2 stage
   localparam int unsigned FracW  = 16;
   localparam int unsigned KW     = 7;
   localparam int unsigned ShiftW = 5;
   localparam int unsigned MantW  = 31;
   localparam int unsigned ProdW  = 62;

   localparam logic [CsrIdxW-1:0] RegBeadCount    = 2'd0;
   localparam logic [CsrIdxW-1:0] RegBandDistance = 2'd1;

   localparam logic [BeadRegW-1:0] BeadCountReset    = 13'd4096;
   localparam logic [BandW-1:0]    BandDistanceReset = 12'd1;

   localparam logic [StatusW-1:0] StatusOk         = 2'd0;
   localparam logic [StatusW-1:0] StatusNoDistal   = 2'd1;
   localparam logic [StatusW-1:0] StatusDistalZero = 2'd2;
   localparam logic [StatusW-1:0] StatusLocalZero  = 2'd3;

   localparam logic [IdxW-1:0] IdxMin = 23'h400000;
   localparam logic [IdxW-1:0] IdxMax = 23'h3FFFFF;

   typedef enum logic [3:0] {
      S_IDLE,
      S_PREP_LOC,
      S_DIV_LOC,
      S_PREP_DIS,
      S_DIV_DIS,
      S_CHECK,
      S_NORM,
      S_DIV_LOG,
      S_SQ_MUL,
      S_SQ_ADJ,
      S_DONE
   } state_type;

   typedef struct packed {
      logic                load;
      logic [DivW-1:0]     dividend;
      logic [DivisorW-1:0] divisor;
      logic [StepW-1:0]    steps;
   } div_cmd_type;

   typedef struct packed {
      logic            busy;
      logic [DivW-1:0] quotient;
   } div_rsp_type;

endpackage

>>> rtl/core/brslr_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Dividend is left aligned; after the requested number of steps the
// quotient sits in the low bits. Depends on brslr_pkg.
module brslr_div (
   input  logic                    clock,
   input  logic                    reset,
   input  brslr_pkg::div_cmd_type  cmd,
   output brslr_pkg::div_rsp_type  rsp
);

   logic                               busy_ff, busy_in;
   logic [brslr_pkg::StepW-1:0]        cnt_ff, cnt_in;
   logic [brslr_pkg::DivisorW-1:0]     rem_ff, rem_in;
   logic [brslr_pkg::DivW-1:0]         quo_ff, quo_in;
   logic [brslr_pkg::DivisorW-1:0]     divisor_ff, divisor_in;

   logic [brslr_pkg::DivisorW:0]       trial;
   logic [brslr_pkg::DivisorW:0]       diff;
   logic                               ge;

   always_comb begin
      trial = {rem_ff, quo_ff[brslr_pkg::DivW-1]};
      diff  = trial - {1'b0, divisor_ff};
      ge    = (trial >= {1'b0, divisor_ff});

      busy_in    = busy_ff;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;

      if (cmd.load) begin
         busy_in    = 1'b1;
         cnt_in     = cmd.steps;
         rem_in     = '0;
         quo_in     = cmd.dividend;
         divisor_in = cmd.divisor;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[brslr_pkg::DivisorW-1:0] : trial[brslr_pkg::DivisorW-1:0];
         quo_in  = {quo_ff[brslr_pkg::DivW-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
         busy_in = (cnt_ff != brslr_pkg::StepW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign rsp.busy     = busy_ff;
   assign rsp.quotient = quo_ff;

   a_no_load_while_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !busy_ff)
      else $error("divider loaded while busy");

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (rem_ff < divisor_ff))
      else $error("partial remainder not below divisor");

   a_busy_ends_on_last_step: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> ($past(cnt_ff) == brslr_pkg::StepW'(1)))
      else $error("divider finished early");

endmodule

>>> rtl/core/banded_row_score_log_ratio_top.sv
// Banded row score with log2 ratio: streams a square matrix, reports per row.
// A request that does not close a row is accepted in IDLE, back to back.
// The closing request starts a sequencer around one shared bit-serial divider
// and a 31x31 squarer; the work until the response is loaded is mostly divider
// steps; requests stall meanwhile and while the last response waits.
// Synchronous reset clears counters and sums, bead_count to 4096, band_distance to 1.
module banded_row_score_log_ratio_top #(
   parameter int unsigned MAX_BEADS = brslr_pkg::MaxBeadsDefault
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [brslr_pkg::ValueW-1:0]        req_contact_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [brslr_pkg::RowW-1:0]          rsp_row_index,
   output logic [brslr_pkg::MeanW-1:0]         rsp_local_mean,
   output logic [brslr_pkg::MeanW-1:0]         rsp_distal_mean,
   output logic signed [brslr_pkg::IdxW-1:0]   rsp_open_index,
   output logic [brslr_pkg::StatusW-1:0]       rsp_status,
   input  logic                                csr_write_enable,
   input  logic [brslr_pkg::CsrIdxW-1:0]       csr_index,
   input  logic [brslr_pkg::CsrDataW-1:0]      csr_write_data
);

   localparam int unsigned RegMax = (1 << brslr_pkg::BeadRegW) - 1;
   localparam int unsigned NMax   = (MAX_BEADS < RegMax) ? MAX_BEADS : RegMax;
   localparam int unsigned CntW   = $clog2(NMax + 1);
   localparam int unsigned CmpW   = brslr_pkg::BeadRegW;
   localparam int unsigned PadW   = brslr_pkg::DivW - brslr_pkg::SumW;

   brslr_pkg::state_type                state_ff, state_in;

   logic [brslr_pkg::BeadRegW-1:0]      bead_ff, bead_in;
   logic [brslr_pkg::BandW-1:0]         band_ff, band_in;

   logic [CntW-1:0]                     row_ff, row_in;
   logic [CntW-1:0]                     col_ff, col_in;
   logic [CntW-1:0]                     local_cnt_ff, local_cnt_in;
   logic [brslr_pkg::SumW-1:0]          local_sum_ff, local_sum_in;
   logic [brslr_pkg::SumW-1:0]          distal_sum_ff, distal_sum_in;

   logic [brslr_pkg::MeanW-1:0]         lmean_ff, lmean_in;
   logic [brslr_pkg::MeanW-1:0]         dmean_ff, dmean_in;
   logic [brslr_pkg::StatusW-1:0]       status_ff, status_in;
   logic [brslr_pkg::IdxW-1:0]          idx_ff, idx_in;

   logic [brslr_pkg::MeanW-1:0]         dn_ff, dn_in;
   logic [brslr_pkg::MeanW-1:0]         ln_ff, ln_in;
   logic [brslr_pkg::ShiftW-1:0]        sa_ff, sa_in;
   logic [brslr_pkg::ShiftW-1:0]        sb_ff, sb_in;
   logic [brslr_pkg::KW-1:0]            k_ff, k_in;
   logic [brslr_pkg::MantW-1:0]         m_ff, m_in;
   logic [brslr_pkg::ProdW-1:0]         prod_ff, prod_in;
   logic [brslr_pkg::FracW-1:0]         frac_ff, frac_in;
   logic [3:0]                          sq_cnt_ff, sq_cnt_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic [brslr_pkg::RowW-1:0]          rsp_row_ff, rsp_row_in;
   logic [brslr_pkg::MeanW-1:0]         rsp_lmean_ff, rsp_lmean_in;
   logic [brslr_pkg::MeanW-1:0]         rsp_dmean_ff, rsp_dmean_in;
   logic [brslr_pkg::IdxW-1:0]          rsp_idx_ff, rsp_idx_in;
   logic [brslr_pkg::StatusW-1:0]       rsp_status_ff, rsp_status_in;

   brslr_pkg::div_cmd_type              div_cmd;
   brslr_pkg::div_rsp_type              div_rsp;

   logic [CntW-1:0]                     n_eff;
   logic [CntW-1:0]                     diag_dist;
   logic [CntW-1:0]                     col_plus;
   logic [CntW-1:0]                     row_plus;
   logic                                in_band;
   logic                                row_end;
   logic                                req_accept;
   logic                                out_free;
   logic [brslr_pkg::SumW:0]            sum_add;
   logic [brslr_pkg::SumW-1:0]          sum_sat;
   logic [brslr_pkg::MeanW-1:0]         sq;
   logic [brslr_pkg::MeanW-1:0]         q_sat;

   brslr_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .rsp   (div_rsp)
   );

   always_comb begin
      if (bead_ff == '0) begin
         n_eff = CntW'(1);
      end else if (32'(bead_ff) > NMax) begin
         n_eff = CntW'(NMax);
      end else begin
         n_eff = CntW'(bead_ff);
      end

      diag_dist = (row_ff >= col_ff) ? (row_ff - col_ff) : (col_ff - row_ff);
      in_band   = (CmpW'(diag_dist) <= CmpW'(band_ff));
      col_plus  = col_ff + 1'b1;
      row_end   = (col_plus >= n_eff);
      row_plus  = row_ff + 1'b1;

      // one adder serves whichever sum the element belongs to
      sum_add = {1'b0, in_band ? local_sum_ff : distal_sum_ff}
              + (brslr_pkg::SumW + 1)'(req_contact_value);
      sum_sat = sum_add[brslr_pkg::SumW] ? '1 : sum_add[brslr_pkg::SumW-1:0];

      q_sat = (div_rsp.quotient[brslr_pkg::SumW-1:brslr_pkg::MeanW] != '0)
            ? '1 : div_rsp.quotient[brslr_pkg::MeanW-1:0];

      sq = prod_ff[brslr_pkg::ProdW-1:brslr_pkg::ProdW-brslr_pkg::MeanW];

      req_accept = req_valid && (state_ff == brslr_pkg::S_IDLE);
      out_free   = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      state_in      = state_ff;
      bead_in       = bead_ff;
      band_in       = band_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      local_cnt_in  = local_cnt_ff;
      local_sum_in  = local_sum_ff;
      distal_sum_in = distal_sum_ff;
      lmean_in      = lmean_ff;
      dmean_in      = dmean_ff;
      status_in     = status_ff;
      idx_in        = idx_ff;
      dn_in         = dn_ff;
      ln_in         = ln_ff;
      sa_in         = sa_ff;
      sb_in         = sb_ff;
      k_in          = k_ff;
      m_in          = m_ff;
      prod_in       = prod_ff;
      frac_in       = frac_ff;
      sq_cnt_in     = sq_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_row_in    = rsp_row_ff;
      rsp_lmean_in  = rsp_lmean_ff;
      rsp_dmean_in  = rsp_dmean_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_status_in = rsp_status_ff;
      div_cmd       = '0;

      if (csr_write_enable) begin
         unique case (csr_index)
            brslr_pkg::RegBeadCount:    bead_in = csr_write_data[brslr_pkg::BeadRegW-1:0];
            brslr_pkg::RegBandDistance: band_in = csr_write_data[brslr_pkg::BandW-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         brslr_pkg::S_IDLE: begin
            if (req_accept) begin
               if (in_band) begin
                  local_sum_in = sum_sat;
                  local_cnt_in = local_cnt_ff + 1'b1;
               end else begin
                  distal_sum_in = sum_sat;
               end
               col_in = col_plus;
               if (row_end) begin
                  state_in = brslr_pkg::S_PREP_LOC;
               end
            end
         end

         brslr_pkg::S_PREP_LOC: begin
            if (local_cnt_ff == '0) begin
               lmean_in = '0;
               state_in = brslr_pkg::S_PREP_DIS;
            end else begin
               div_cmd.load     = 1'b1;
               div_cmd.dividend = {local_sum_ff, {PadW{1'b0}}};
               div_cmd.divisor  = brslr_pkg::DivisorW'(local_cnt_ff);
               div_cmd.steps    = brslr_pkg::StepW'(brslr_pkg::SumW);
               state_in         = brslr_pkg::S_DIV_LOC;
            end
         end

         brslr_pkg::S_DIV_LOC: begin
            if (!div_rsp.busy) begin
               lmean_in = q_sat;
               state_in = brslr_pkg::S_PREP_DIS;
            end
         end

         brslr_pkg::S_PREP_DIS: begin
            if (local_cnt_ff >= n_eff) begin
               dmean_in  = '0;
               status_in = brslr_pkg::StatusNoDistal;
               idx_in    = brslr_pkg::IdxMin;
               state_in  = brslr_pkg::S_DONE;
            end else begin
               div_cmd.load     = 1'b1;
               div_cmd.dividend = {distal_sum_ff, {PadW{1'b0}}};
               div_cmd.divisor  = brslr_pkg::DivisorW'(n_eff - local_cnt_ff);
               div_cmd.steps    = brslr_pkg::StepW'(brslr_pkg::SumW);
               state_in         = brslr_pkg::S_DIV_DIS;
            end
         end

         brslr_pkg::S_DIV_DIS: begin
            if (!div_rsp.busy) begin
               dmean_in = q_sat;
               state_in = brslr_pkg::S_CHECK;
            end
         end

         brslr_pkg::S_CHECK: begin
            if (dmean_ff == '0) begin
               status_in = brslr_pkg::StatusDistalZero;
               idx_in    = brslr_pkg::IdxMin;
               state_in  = brslr_pkg::S_DONE;
            end else if (lmean_ff == '0) begin
               status_in = brslr_pkg::StatusLocalZero;
               idx_in    = brslr_pkg::IdxMax;
               state_in  = brslr_pkg::S_DONE;
            end else begin
               dn_in    = dmean_ff;
               ln_in    = lmean_ff;
               sa_in    = '0;
               sb_in    = '0;
               state_in = brslr_pkg::S_NORM;
            end
         end

         brslr_pkg::S_NORM: begin
            if (dn_ff[brslr_pkg::MeanW-1] && ln_ff[brslr_pkg::MeanW-1]) begin
               // both normalized: pick the scaling that keeps the ratio in [1,2)
               div_cmd.load    = 1'b1;
               div_cmd.divisor = ln_ff;
               div_cmd.steps   = brslr_pkg::StepW'(brslr_pkg::DivW);
               if (dn_ff >= ln_ff) begin
                  div_cmd.dividend = {2'b00, dn_ff, 30'd0};
                  k_in = brslr_pkg::KW'(sb_ff) - brslr_pkg::KW'(sa_ff);
               end else begin
                  div_cmd.dividend = {1'b0, dn_ff, 31'd0};
                  k_in = brslr_pkg::KW'(sb_ff) - brslr_pkg::KW'(sa_ff)
                       - brslr_pkg::KW'(1);
               end
               state_in = brslr_pkg::S_DIV_LOG;
            end else begin
               if (!dn_ff[brslr_pkg::MeanW-1]) begin
                  dn_in = {dn_ff[brslr_pkg::MeanW-2:0], 1'b0};
                  sa_in = sa_ff + 1'b1;
               end
               if (!ln_ff[brslr_pkg::MeanW-1]) begin
                  ln_in = {ln_ff[brslr_pkg::MeanW-2:0], 1'b0};
                  sb_in = sb_ff + 1'b1;
               end
            end
         end

         brslr_pkg::S_DIV_LOG: begin
            if (!div_rsp.busy) begin
               m_in      = div_rsp.quotient[brslr_pkg::MantW-1:0];
               frac_in   = '0;
               sq_cnt_in = '0;
               state_in  = brslr_pkg::S_SQ_MUL;
            end
         end

         brslr_pkg::S_SQ_MUL: begin
            prod_in  = m_ff * m_ff;
            state_in = brslr_pkg::S_SQ_ADJ;
         end

         brslr_pkg::S_SQ_ADJ: begin
            // square reached 2 or more: emit a one and halve; else emit a zero and keep it
            frac_in = {frac_ff[brslr_pkg::FracW-2:0], sq[brslr_pkg::MeanW-1]};
            m_in    = sq[brslr_pkg::MeanW-1] ? sq[brslr_pkg::MeanW-1:1]
                                             : sq[brslr_pkg::MantW-1:0];
            if (sq_cnt_ff == 4'd15) begin
               idx_in    = {k_ff, frac_in};
               status_in = brslr_pkg::StatusOk;
               state_in  = brslr_pkg::S_DONE;
            end else begin
               sq_cnt_in = sq_cnt_ff + 1'b1;
               state_in  = brslr_pkg::S_SQ_MUL;
            end
         end

         brslr_pkg::S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_row_in    = brslr_pkg::RowW'(row_ff);
               rsp_lmean_in  = lmean_ff;
               rsp_dmean_in  = dmean_ff;
               rsp_idx_in    = idx_ff;
               rsp_status_in = status_ff;
               col_in        = '0;
               local_cnt_in  = '0;
               local_sum_in  = '0;
               distal_sum_in = '0;
               row_in        = (row_plus >= n_eff) ? '0 : row_plus;
               state_in      = brslr_pkg::S_IDLE;
            end
         end

         default: state_in = brslr_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= brslr_pkg::S_IDLE;
         bead_ff       <= brslr_pkg::BeadCountReset;
         band_ff       <= brslr_pkg::BandDistanceReset;
         row_ff        <= '0;
         col_ff        <= '0;
         local_cnt_ff  <= '0;
         local_sum_ff  <= '0;
         distal_sum_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         bead_ff       <= bead_in;
         band_ff       <= band_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         local_cnt_ff  <= local_cnt_in;
         local_sum_ff  <= local_sum_in;
         distal_sum_ff <= distal_sum_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lmean_ff      <= lmean_in;
      dmean_ff      <= dmean_in;
      status_ff     <= status_in;
      idx_ff        <= idx_in;
      dn_ff         <= dn_in;
      ln_ff         <= ln_in;
      sa_ff         <= sa_in;
      sb_ff         <= sb_in;
      k_ff          <= k_in;
      m_ff          <= m_in;
      prod_ff       <= prod_in;
      frac_ff       <= frac_in;
      sq_cnt_ff     <= sq_cnt_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_lmean_ff  <= rsp_lmean_in;
      rsp_dmean_ff  <= rsp_dmean_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_stall       = (state_ff != brslr_pkg::S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_row_index   = rsp_row_ff;
   assign rsp_local_mean  = rsp_lmean_ff;
   assign rsp_distal_mean = rsp_dmean_ff;
   assign rsp_open_index  = rsp_idx_ff;
   assign rsp_status      = rsp_status_ff;

   a_local_within_columns: assert property (@(posedge clock) disable iff (reset)
      local_cnt_ff <= col_ff)
      else $error("local count exceeds columns seen");

   a_row_end_starts_scoring: assert property (@(posedge clock) disable iff (reset)
      (req_accept && row_end) |=> (state_ff == brslr_pkg::S_PREP_LOC))
      else $error("row end did not start scoring");

   a_response_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == brslr_pkg::S_DONE))
      else $error("response appeared outside completion");

   a_accumulators_cleared: assert property (@(posedge clock) disable iff (reset)
      ($past(state_ff) == brslr_pkg::S_DONE && state_ff == brslr_pkg::S_IDLE)
      |-> (col_ff == '0 && local_cnt_ff == '0))
      else $error("row state not cleared after response");

endmodule
